// File: rtl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must be false at every clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication broken");

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication broken");

`endif

// File: rtl/i2cms_pkg.sv
// Types and constants of the I2C master transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none
package i2cms_pkg;

    localparam logic [1:0] ACT_LOAD_DESC = 2'd0;
    localparam logic [1:0] ACT_LOAD_BYTE = 2'd1;
    localparam logic [1:0] ACT_START_SEQ = 2'd2;
    localparam logic [1:0] ACT_BUS_EVENT = 2'd3;

    localparam logic [2:0] EV_START_DONE   = 3'd0;
    localparam logic [2:0] EV_RESTART_DONE = 3'd1;
    localparam logic [2:0] EV_ADDR_WR_ACK  = 3'd2;
    localparam logic [2:0] EV_DATA_WR_ACK  = 3'd3;
    localparam logic [2:0] EV_ADDR_RD_ACK  = 3'd4;
    localparam logic [2:0] EV_RD_ACK       = 3'd5;
    localparam logic [2:0] EV_RD_NACK      = 3'd6;
    localparam logic [2:0] EV_OTHER_ERR    = 3'd7;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_NACK  = 3'd3;
    localparam logic [2:0] CMD_SEND  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] event_code;
        logic [7:0] rx_byte;
        logic [6:0] dev_address;
        logic       is_read;
        logic [7:0] xfer_length;
        logic [7:0] wr_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] tx_byte;
        logic [1:0] seq_status;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic [3:0] cur_transfer;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_LOAD_DESC = 2'd0,
        OP_LOAD_BYTE = 2'd1,
        OP_START_SEQ = 2'd2,
        OP_EVENT     = 2'd3
    } t_op;

    // classified request handed from the front end to the execution stage
    typedef struct packed {
        t_op        op;
        logic [2:0] event_code;
        logic [7:0] rx_byte;
        logic [7:0] addr_byte;
        logic [7:0] xfer_length;
        logic [7:0] wr_byte;
    } t_req;

endpackage
`default_nettype wire

// File: rtl/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/i2cms_front.sv
// Front end: accepts requests, classifies them and queues them for execution.
`timescale 1ns / 1ps
`default_nettype none
module i2cms_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire i2cms_pkg::t_in_item i_in_item,
    output logic                     o_req_valid,
    output i2cms_pkg::t_req          o_req,
    input  wire logic                i_req_pop
);
    import i2cms_pkg::*;

    t_req       cls;
    t_req       r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    always_comb begin
        cls.event_code  = i_in_item.event_code;
        cls.rx_byte     = i_in_item.rx_byte;
        cls.addr_byte   = {i_in_item.dev_address, i_in_item.is_read};
        cls.xfer_length = i_in_item.xfer_length;
        cls.wr_byte     = i_in_item.wr_byte;
        unique case (i_in_item.action)
            ACT_LOAD_DESC: cls.op = OP_LOAD_DESC;
            ACT_LOAD_BYTE: cls.op = OP_LOAD_BYTE;
            ACT_START_SEQ: cls.op = OP_START_SEQ;
            ACT_BUS_EVENT: cls.op = OP_EVENT;
        endcase
    end

    assign o_in_stall  = r_cnt[1];
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_slot[r_rd_ptr];
    assign push        = i_in_valid && !r_cnt[1];
    assign pop         = i_req_pop && o_req_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

endmodule
`default_nettype wire

// File: rtl/i2cms_back.sv
// Back end: executes queued requests against the transfer list and issues commands.
`timescale 1ns / 1ps
`default_nettype none
module i2cms_back #(
    parameter int MAX_TRANSFERS = 8,
    parameter int BUFFER_DEPTH  = 256,
    localparam int AW = $clog2(BUFFER_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    input  wire i2cms_pkg::t_req      i_req,
    output logic                      o_req_pop,
    output logic                      o_out_valid,
    output i2cms_pkg::t_out_item      o_out_item,
    input  wire logic                 i_out_stall,
    output logic                      o_ram_wr_en,
    output logic [AW-1:0]             o_ram_wr_addr,
    output logic [7:0]                o_ram_wr_data,
    output logic                      o_ram_rd_en,
    output logic [AW-1:0]             o_ram_rd_addr,
    input  wire logic [7:0]           i_ram_rd_data
);
    import i2cms_pkg::*;

    localparam int CNT_W  = $clog2(MAX_TRANSFERS + 1);
    localparam int IDX_W  = (MAX_TRANSFERS > 1) ? $clog2(MAX_TRANSFERS) : 1;
    localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]        r_desc_addr [MAX_TRANSFERS];
    logic [7:0]        r_desc_len  [MAX_TRANSFERS];
    logic [AW-1:0]     r_desc_base [MAX_TRANSFERS];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_index, n_index;
    logic [7:0]        r_pos, n_pos;
    logic              r_pos_ovf, n_pos_ovf;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_status, n_status;
    logic              r_used, n_used;

    logic              r_p_valid, n_p_valid;
    t_out_item         r_p_item, n_p_item;
    logic              r_p_from_ram, n_p_from_ram;

    logic              fire;
    logic              busy;
    logic [IDX_W-1:0]  cur;
    logic [7:0]        len;
    logic [AW-1:0]     at;
    logic [AW-1:0]     at_next;
    logic              pos_ne_len;
    logic              pos1_eq_len;
    logic              pos2_eq_len;
    logic [CNT_W-1:0]  cnt_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [CNT_W-1:0]  index_next;
    logic              do_send, do_next, do_fail, do_bump;
    logic              desc_we;
    logic [IDX_W-1:0]  desc_widx;
    logic [AW-1:0]     desc_wbase;

    assign fire      = i_req_valid && (!r_p_valid || !i_out_stall);
    assign o_req_pop = fire;
    assign busy      = (r_status == ST_BUSY);
    assign cur       = r_index[IDX_W-1:0];
    assign len       = r_desc_len[cur];
    assign at        = (r_pos == 8'd0 && !r_pos_ovf) ? r_desc_base[cur] : r_ptr;
    assign at_next   = (at == AW'(BUFFER_DEPTH - 1)) ? '0 : at + 1'b1;
    assign pos_ne_len  = r_pos_ovf || (r_pos != len);
    assign pos1_eq_len = !r_pos_ovf && (({1'b0, r_pos} + 9'd1) == {1'b0, len});
    assign pos2_eq_len = !r_pos_ovf && (({2'b0, r_pos} + 10'd2) == {2'b0, len});
    assign cnt_eff     = r_used ? '0 : r_count;
    assign fill_eff    = r_used ? '0 : r_fill;
    assign index_next  = r_index + 1'b1;
    assign desc_widx   = cnt_eff[IDX_W-1:0];
    assign desc_wbase  = (fill_eff == FILL_W'(BUFFER_DEPTH)) ? '0 : fill_eff[AW-1:0];

    assign o_ram_wr_addr = fill_eff[AW-1:0];
    assign o_ram_wr_data = i_req.wr_byte;
    assign o_ram_rd_addr = at;

    always_comb begin
        n_count      = r_count;
        n_index      = r_index;
        n_pos        = r_pos;
        n_pos_ovf    = r_pos_ovf;
        n_ptr        = r_ptr;
        n_fill       = r_fill;
        n_status     = r_status;
        n_used       = r_used;
        n_p_item     = r_p_item;
        n_p_from_ram = r_p_from_ram;
        n_p_valid    = i_out_stall ? r_p_valid : 1'b0;
        do_send      = 1'b0;
        do_next      = 1'b0;
        do_fail      = 1'b0;
        do_bump      = 1'b0;
        desc_we      = 1'b0;
        o_ram_wr_en  = 1'b0;
        o_ram_rd_en  = 1'b0;

        if (fire) begin
            n_p_valid    = 1'b1;
            n_p_from_ram = 1'b0;
            n_p_item     = '0;
            n_p_item.bus_command = CMD_NONE;

            unique case (i_req.op)
                OP_LOAD_DESC: begin
                    if (!busy) begin
                        n_used  = 1'b0;
                        n_fill  = fill_eff;
                        n_count = cnt_eff;
                        if (cnt_eff < CNT_W'(MAX_TRANSFERS)) begin
                            desc_we = 1'b1;
                            n_count = cnt_eff + 1'b1;
                        end
                    end
                end
                OP_LOAD_BYTE: begin
                    if (!busy) begin
                        n_used  = 1'b0;
                        n_count = cnt_eff;
                        n_fill  = fill_eff;
                        if (fill_eff < FILL_W'(BUFFER_DEPTH)) begin
                            o_ram_wr_en = 1'b1;
                            n_fill      = fill_eff + 1'b1;
                        end
                    end
                end
                OP_START_SEQ: begin
                    if (!busy && r_count != '0) begin
                        n_index   = '0;
                        n_pos     = 8'd0;
                        n_pos_ovf = 1'b0;
                        n_status  = ST_BUSY;
                        n_used    = 1'b1;
                        n_p_item.bus_command = CMD_START;
                    end
                end
                OP_EVENT: begin
                    if (busy && r_index < r_count) begin
                        unique case (i_req.event_code)
                            EV_START_DONE, EV_RESTART_DONE: begin
                                n_p_item.bus_command = CMD_SEND;
                                n_p_item.tx_byte     = r_desc_addr[cur];
                            end
                            EV_ADDR_WR_ACK: begin
                                if (len != 8'd0) do_send = 1'b1;
                                else do_next = 1'b1;
                            end
                            EV_DATA_WR_ACK: begin
                                if (pos_ne_len) do_send = 1'b1;
                                else do_next = 1'b1;
                            end
                            EV_ADDR_RD_ACK: begin
                                if (len == 8'd1) n_p_item.bus_command = CMD_NACK;
                                else if (len == 8'd0) do_next = 1'b1;
                            end
                            EV_RD_ACK: begin
                                if (pos_ne_len) begin
                                    do_bump = 1'b1;
                                    n_p_item.rd_valid = 1'b1;
                                    n_p_item.rd_byte  = i_req.rx_byte;
                                    if (pos2_eq_len) n_p_item.bus_command = CMD_NACK;
                                end else begin
                                    do_fail = 1'b1;
                                end
                            end
                            EV_RD_NACK: begin
                                if (len != 8'd0 && pos1_eq_len) begin
                                    do_bump = 1'b1;
                                    do_next = 1'b1;
                                    n_p_item.rd_valid = 1'b1;
                                    n_p_item.rd_byte  = i_req.rx_byte;
                                end else begin
                                    do_fail = 1'b1;
                                end
                            end
                            EV_OTHER_ERR: do_fail = 1'b1;
                        endcase
                    end
                end
            endcase

            if (do_send) begin
                do_bump      = 1'b1;
                o_ram_rd_en  = 1'b1;
                n_p_from_ram = 1'b1;
                n_status     = ST_BUSY;
                n_p_item.bus_command = CMD_SEND;
            end
            if (do_bump) begin
                n_pos     = r_pos + 8'd1;
                n_pos_ovf = r_pos_ovf | (&r_pos);
                n_ptr     = at_next;
            end
            if (do_next) begin
                n_index   = index_next;
                n_pos     = 8'd0;
                n_pos_ovf = 1'b0;
                if (index_next >= r_count) begin
                    n_p_item.bus_command = CMD_STOP;
                    n_status             = ST_OK;
                end else begin
                    n_p_item.bus_command = CMD_START;
                    n_status             = ST_BUSY;
                end
            end
            if (do_fail) begin
                n_p_item.bus_command = CMD_STOP;
                n_status             = ST_ERR;
            end

            n_p_item.seq_status   = n_status;
            n_p_item.cur_transfer = 4'(n_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_index   <= '0;
            r_pos     <= 8'd0;
            r_pos_ovf <= 1'b0;
            r_fill    <= '0;
            r_status  <= ST_OK;
            r_used    <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_index   <= n_index;
            r_pos     <= n_pos;
            r_pos_ovf <= n_pos_ovf;
            r_fill    <= n_fill;
            r_status  <= n_status;
            r_used    <= n_used;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_p_item     <= n_p_item;
        r_p_from_ram <= n_p_from_ram;
        if (desc_we) begin
            r_desc_addr[desc_widx] <= i_req.addr_byte;
            r_desc_len[desc_widx]  <= i_req.xfer_length;
            r_desc_base[desc_widx] <= desc_wbase;
        end
    end

    always_comb begin
        o_out_item = r_p_item;
        if (r_p_from_ram) begin
            o_out_item.tx_byte = i_ram_rd_data;
        end
    end
    assign o_out_valid = r_p_valid;

endmodule
`default_nettype wire

// File: rtl/i2c_master_transaction_sequencer_unit.sv
// Top level of the I2C master transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Takes one request per cycle while the queue has room; returns exactly one result
// per request, in order. A request enters a two-entry queue at the accepting edge
// and is executed by the back end once the output register is free, which holds its
// result. The execution stage handles one request per cycle unless output stalls,
// and the write-byte RAM has one write and one read port with registered read data,
// which sets the sustained rate at one request per cycle. The output register and
// the queue let the input keep accepting while a result waits to be taken.
module i2c_master_transaction_sequencer_unit #(
    parameter int MAX_TRANSFERS = 8,
    parameter int BUFFER_DEPTH  = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire i2cms_pkg::t_in_item  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output i2cms_pkg::t_out_item      o_out_item
);
    import i2cms_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic          req_valid;
    t_req          req;
    logic          req_pop;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    i2cms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    i2cms_back #(
        .MAX_TRANSFERS (MAX_TRANSFERS),
        .BUFFER_DEPTH  (BUFFER_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req         (req),
        .o_req_pop     (req_pop),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_stall   (i_out_stall),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_wr_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // buffer loads happen only while idle, buffer reads only while busy
    `ASSERT_NEVER(a_ram_rw_same_cycle, i_clk, i_rst_n, ram_wr_en && ram_rd_en)
    // a buffer read always lands in the output register on the next cycle
    `ASSERT_NEXT(a_rd_to_out, i_clk, i_rst_n, ram_rd_en, o_out_valid)
    // a delivered read byte never rides with a send command
    `ASSERT_IMPLY(a_rd_no_send, i_clk, i_rst_n, o_out_valid && o_out_item.rd_valid, o_out_item.bus_command != CMD_SEND)
    // sending a byte only happens while the sequence is running
    `ASSERT_IMPLY(a_send_busy, i_clk, i_rst_n, o_out_valid && o_out_item.bus_command == CMD_SEND, o_out_item.seq_status == ST_BUSY)

endmodule
`default_nettype wire

// File: tb/i2cms_checker.sv
// Result checker for the I2C master transaction sequencer: predicts and compares results.
`timescale 1ns / 1ps
module i2cms_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  i2cms_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  i2cms_pkg::t_out_item i_out_item,
    output int                   o_errors,
    output int                   o_pending
);
    import i2cms_pkg::*;

    localparam int MAX_SLOTS = 8;
    localparam int BUF_DEPTH = 256;

    logic [7:0] slot_addr [MAX_SLOTS];
    logic [7:0] slot_len  [MAX_SLOTS];
    int         slot_base [MAX_SLOTS];
    logic [7:0] wbuf      [BUF_DEPTH];
    int         n_slots;
    int         slot_idx;
    int         pos;
    int         fill;
    logic [1:0] seq_st;
    bit         list_done;

    t_out_item  result_q [$];
    int         errors  = 0;
    int         pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    // first load after a begun list starts a fresh one
    function automatic void open_list();
        if (list_done) begin
            n_slots   = 0;
            fill      = 0;
            list_done = 1'b0;
        end
    endfunction

    function automatic void end_transfer(inout t_out_item r);
        slot_idx++;
        pos = 0;
        if (slot_idx >= n_slots) begin
            r.bus_command = CMD_STOP;
            seq_st        = ST_OK;
        end else begin
            r.bus_command = CMD_START;
            seq_st        = ST_BUSY;
        end
    endfunction

    function automatic void send_payload(inout t_out_item r);
        r.bus_command = CMD_SEND;
        r.tx_byte     = wbuf[(slot_base[slot_idx] + pos) % BUF_DEPTH];
        pos++;
        seq_st = ST_BUSY;
    endfunction

    function automatic void abort_transfer(inout t_out_item r);
        r.bus_command = CMD_STOP;
        seq_st        = ST_ERR;
    endfunction

    function automatic t_out_item sequence_request(input t_in_item rq);
        t_out_item r;
        int        len;
        r = '0;
        case (rq.action)
            ACT_LOAD_DESC: if (seq_st != ST_BUSY) begin
                open_list();
                if (n_slots < MAX_SLOTS) begin
                    slot_addr[n_slots] = {rq.dev_address, rq.is_read};
                    slot_len[n_slots]  = rq.xfer_length;
                    slot_base[n_slots] = fill;
                    n_slots++;
                end
            end
            ACT_LOAD_BYTE: if (seq_st != ST_BUSY) begin
                open_list();
                if (fill < BUF_DEPTH) begin
                    wbuf[fill] = rq.wr_byte;
                    fill++;
                end
            end
            ACT_START_SEQ: if (seq_st != ST_BUSY && n_slots != 0) begin
                slot_idx      = 0;
                pos           = 0;
                seq_st        = ST_BUSY;
                list_done     = 1'b1;
                r.bus_command = CMD_START;
            end
            default: if (seq_st == ST_BUSY && slot_idx < n_slots) begin
                len = slot_len[slot_idx];
                case (rq.event_code)
                    EV_START_DONE, EV_RESTART_DONE: begin
                        r.bus_command = CMD_SEND;
                        r.tx_byte     = slot_addr[slot_idx];
                    end
                    EV_ADDR_WR_ACK: begin
                        if (len != 0) send_payload(r);
                        else end_transfer(r);
                    end
                    EV_DATA_WR_ACK: begin
                        if (pos != len) send_payload(r);
                        else end_transfer(r);
                    end
                    EV_ADDR_RD_ACK: begin
                        if (len == 1) r.bus_command = CMD_NACK;
                        else if (len == 0) end_transfer(r);
                    end
                    EV_RD_ACK: if (pos != len) begin
                        r.rd_valid = 1'b1;
                        r.rd_byte  = rq.rx_byte;
                        pos++;
                        if (pos + 1 == len) r.bus_command = CMD_NACK;
                    end else begin
                        abort_transfer(r);
                    end
                    EV_RD_NACK: if (len != 0 && pos + 1 == len) begin
                        r.rd_valid = 1'b1;
                        r.rd_byte  = rq.rx_byte;
                        pos++;
                        end_transfer(r);
                    end else begin
                        abort_transfer(r);
                    end
                    default: abort_transfer(r);
                endcase
            end
        endcase
        r.seq_status   = seq_st;
        r.cur_transfer = slot_idx[3:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            n_slots   = 0;
            slot_idx  = 0;
            pos       = 0;
            fill      = 0;
            seq_st    = ST_OK;
            list_done = 1'b0;
            result_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) result_q.push_back(sequence_request(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unrequested result", 8'(i_out_item.bus_command), 8'h00);
                end else begin
                    want = result_q.pop_front();
                    if (i_out_item.bus_command !== want.bus_command)
                        report_mismatch("bus_command", 8'(i_out_item.bus_command),
                                        8'(want.bus_command));
                    if (i_out_item.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", i_out_item.tx_byte, want.tx_byte);
                    if (i_out_item.seq_status !== want.seq_status)
                        report_mismatch("seq_status", 8'(i_out_item.seq_status),
                                        8'(want.seq_status));
                    if (i_out_item.rd_valid !== want.rd_valid)
                        report_mismatch("rd_valid", 8'(i_out_item.rd_valid),
                                        8'(want.rd_valid));
                    if (i_out_item.rd_byte !== want.rd_byte)
                        report_mismatch("rd_byte", i_out_item.rd_byte, want.rd_byte);
                    if (i_out_item.cur_transfer !== want.cur_transfer)
                        report_mismatch("cur_transfer", 8'(i_out_item.cur_transfer),
                                        8'(want.cur_transfer));
                end
            end
        end
        pending = result_q.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the sequencer testbench: clock, reset, request stimulus, stall control and verdict.
`timescale 1ns / 1ps
module testbench;
    import i2cms_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 700;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    int errors;
    int pending;
    int n_sent       = 0;
    int quiet_cycles = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_stall_on  = 1'b1;
    bit hold_off     = 1'b0;

    i2c_master_transaction_sequencer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    i2cms_checker seq_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("i2c_master_transaction_sequencer_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin : receiver
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            out_stall <= rx_stall_on && ($urandom_range(99) < 36);
        end
    end

    function automatic t_in_item random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    // entered and left at a falling edge
    task automatic push_request(input t_in_item it);
        while (tx_idle_on && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send_desc(input logic [6:0] addr, input bit rd, input logic [7:0] len);
        t_in_item it;
        it             = random_item();
        it.action      = ACT_LOAD_DESC;
        it.dev_address = addr;
        it.is_read     = rd;
        it.xfer_length = len;
        push_request(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it         = random_item();
        it.action  = ACT_LOAD_BYTE;
        it.wr_byte = b;
        push_request(it);
    endtask

    task automatic send_begin();
        t_in_item it;
        it        = random_item();
        it.action = ACT_START_SEQ;
        push_request(it);
    endtask

    task automatic send_event(input logic [2:0] code, input logic [7:0] rx);
        t_in_item it;
        it            = random_item();
        it.action     = ACT_BUS_EVENT;
        it.event_code = code;
        it.rx_byte    = rx;
        push_request(it);
    endtask

    // bus event of a well-formed list; now and then a stray code breaks the list
    task automatic list_event(input logic [2:0] code, inout bit broken);
        if (broken) return;
        if ($urandom_range(99) < 3) begin
            send_event(3'($urandom), 8'($urandom));
            send_event(EV_OTHER_ERR, 8'($urandom));
            broken = 1'b1;
        end else begin
            send_event(code, 8'($urandom));
        end
    endtask

    task automatic run_list();
        int lens [10];
        bit dirs [10];
        int n_desc;
        int n_bytes;
        int d;
        int b;
        int j;
        bit broken;
        bit flip;
        n_desc  = ($urandom_range(99) < 5) ? $urandom_range(10, 9) : $urandom_range(8, 1);
        n_bytes = $urandom_range(12, 0);
        for (d = 0; d < n_desc; d++) begin
            dirs[d] = 1'($urandom_range(1));
            if ($urandom_range(99) < 1)
                lens[d] = $urandom_range(1) ? 255 : $urandom_range(255);
            else if ($urandom_range(99) < 8)
                lens[d] = $urandom_range(20, 5);
            else
                lens[d] = $urandom_range(4, 0);
        end
        d = 0;
        b = 0;
        while (d < n_desc || b < n_bytes) begin
            if (b >= n_bytes || (d < n_desc && $urandom_range(1))) begin
                send_desc(7'($urandom), dirs[d], 8'(lens[d]));
                d++;
            end else begin
                send_byte(8'($urandom));
                b++;
            end
        end
        send_begin();
        broken = 1'b0;
        for (d = 0; d < n_desc && d < 8 && !broken; d++) begin
            flip = ($urandom_range(99) < 10);
            list_event($urandom_range(1) ? EV_START_DONE : EV_RESTART_DONE, broken);
            if (dirs[d] ^ flip) begin
                list_event(EV_ADDR_RD_ACK, broken);
                if (lens[d] > 0) begin
                    for (j = 1; j < lens[d]; j++) list_event(EV_RD_ACK, broken);
                    list_event(EV_RD_NACK, broken);
                end
            end else begin
                list_event(EV_ADDR_WR_ACK, broken);
                for (j = 0; j < lens[d]; j++) list_event(EV_DATA_WR_ACK, broken);
            end
        end
    endtask

    task automatic noise_burst();
        int k;
        for (k = $urandom_range(6, 1); k > 0; k--) push_request(random_item());
        // leave the block idle with its list marked as used
        send_begin();
        send_event(EV_OTHER_ERR, 8'($urandom));
    endtask

    initial begin : stimulus
        int  k;
        int  rand_start;
        bit  hold_done;
        bit  quiet;
        in_valid  = 1'b0;
        in_item   = '0;
        hold_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every write buffer entry written once; the last load finds it full
        for (k = 0; k <= 256; k++)
            send_byte(k == 0 ? 8'h00 : (k == 1 ? 8'hFF : 8'($urandom)));

        send_event(EV_OTHER_ERR, 8'hFF);
        send_begin();
        send_desc(7'h7F, 1'b0, 8'd2);
        send_desc(7'h00, 1'b1, 8'd3);
        send_desc(7'h55, 1'b1, 8'd0);
        send_desc(7'h2A, 1'b1, 8'd1);
        send_desc(7'h7F, 1'b1, 8'd255);
        send_begin();
        send_byte(8'h00);
        send_begin();
        send_event(EV_START_DONE, 8'h00);
        send_event(EV_ADDR_WR_ACK, 8'hFF);
        send_event(EV_DATA_WR_ACK, 8'h00);
        send_event(EV_DATA_WR_ACK, 8'hFF);
        send_event(EV_RESTART_DONE, 8'h00);
        send_event(EV_ADDR_RD_ACK, 8'hFF);
        send_event(EV_RD_ACK, 8'h00);
        send_event(EV_RD_ACK, 8'hFF);
        send_event(EV_RD_NACK, 8'hA5);
        send_event(EV_RESTART_DONE, 8'h00);
        send_event(EV_ADDR_RD_ACK, 8'h00);
        send_event(EV_RESTART_DONE, 8'h00);
        send_event(EV_ADDR_RD_ACK, 8'h00);
        send_event(EV_RD_NACK, 8'h5A);
        send_event(EV_RESTART_DONE, 8'h00);
        send_event(EV_RD_NACK, 8'h3C);

        rand_start = n_sent;
        while (n_sent < rand_start + RANDOM_ITEMS) begin
            quiet       = (n_sent - rand_start > 300) && (n_sent - rand_start < 500);
            tx_idle_on  = !quiet;
            rx_stall_on = !quiet;
            if (!hold_done && n_sent - rand_start > 650) begin
                hold_off  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(99) < 85) run_list();
            else noise_burst();
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("i2c_master_transaction_sequencer_unit regression: pass");
        else
            $display("i2c_master_transaction_sequencer_unit regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_ram.sv
rtl/i2cms_front.sv
rtl/i2cms_back.sv
rtl/i2c_master_transaction_sequencer_unit.sv
tb/i2cms_checker.sv
tb/testbench.sv
